/* design/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared codes for the sorted key table: operation and status encodings.
// ----------------------------------------------------------------------------
package skt_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_DUP     = 2'd1;
    localparam status_t ST_MISSING = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

endpackage

/* design/skt_req_if.sv */
// ----------------------------------------------------------------------------
// skt_req_if
// Request channel: one operation on one key per word.
// ----------------------------------------------------------------------------
interface skt_req_if #(
    parameter int KEY_BITS = 16
);
    import skt_pkg::*;

    logic                valid;
    logic                ready;
    op_t                 operation;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);

endinterface

/* design/skt_rsp_if.sv */
// ----------------------------------------------------------------------------
// skt_rsp_if
// Response channel: status, rank and occupancy, one word per request.
// ----------------------------------------------------------------------------
interface skt_rsp_if #(
    parameter int POS_BITS = 6,
    parameter int OCC_BITS = 7
);
    import skt_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [POS_BITS-1:0] position;
    logic [OCC_BITS-1:0] occupancy;

    modport source (output valid, output status, output position, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    output ready);

endinterface

/* design/sorted_key_table.sv */
// Scan and shift: each takes one key-store access per cycle.
// Throughput: one request at a time; the next is taken once the response is
// in the output register, which holds it while the next request runs.
// Reset: occupancy clears to zero; the key store is not cleared, since only
// entries below the occupancy are ever read.
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table of unique keys kept in ascending order in one synchronous
// RAM. Scans for the rank, then shifts entries to insert or remove.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);
    import skt_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_INS    = 3'd3;
    localparam logic [2:0] S_INSK   = 3'd4;
    localparam logic [2:0] S_REM    = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    op_t                 op_reg,      op_next;
    logic [KEY_BITS-1:0] key_reg,     key_next;
    logic [PTR_W-1:0]    ptr_reg,     ptr_next;
    logic [CNT_W-1:0]    rank_reg,    rank_next;
    logic                present_reg, present_next;
    status_t             status_reg,  status_next;
    logic [PTR_W-1:0]    pos_reg,     pos_next;

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [PTR_W-1:0]    mem_waddr;
    logic [PTR_W-1:0]    mem_raddr;
    logic [KEY_BITS-1:0] mem_wdata;

    logic                rsp_load;
    logic                rsp_free;
    logic [CNT_W-1:0]    ptr_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign ptr_ext   = CNT_W'(ptr_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        ptr_next     = ptr_reg;
        rank_next    = rank_reg;
        present_next = present_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = '0;
        mem_raddr    = '0;
        mem_wdata    = key_reg;
        rsp_load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.operation;
                    key_next = req.key;
                    ptr_next = '0;
                    if (count_reg == '0)
                    begin
                        rank_next    = '0;
                        present_next = 1'b0;
                        state_next   = S_DECIDE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_CMP;
                    end
                end
            end

            S_CMP:
            begin
                if (rd_data_reg >= key_reg)
                begin
                    rank_next    = ptr_ext;
                    present_next = (rd_data_reg == key_reg);
                    state_next   = S_DECIDE;
                end
                else if (ptr_ext + CNT_W'(1) == count_reg)
                begin
                    rank_next    = count_reg;
                    present_next = 1'b0;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    ptr_next  = ptr_reg + PTR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + PTR_W'(1);
                end
            end

            S_DECIDE:
            begin
                status_next = ST_OK;
                pos_next    = PTR_W'(rank_reg);
                state_next  = S_RESP;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (present_reg)
                        begin
                            status_next = ST_DUP;
                            pos_next    = '0;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            pos_next    = '0;
                        end
                        else if (rank_reg == count_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = PTR_W'(rank_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ptr_next   = PTR_W'(count_reg - CNT_W'(1));
                            mem_re     = 1'b1;
                            mem_raddr  = PTR_W'(count_reg - CNT_W'(1));
                            state_next = S_INS;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!present_reg)
                        begin
                            status_next = ST_MISSING;
                            pos_next    = '0;
                        end
                        else if (rank_reg + CNT_W'(1) == count_reg)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            ptr_next   = PTR_W'(rank_reg + CNT_W'(1));
                            mem_re     = 1'b1;
                            mem_raddr  = PTR_W'(rank_reg + CNT_W'(1));
                            state_next = S_REM;
                        end
                    end
                    default:
                    begin
                        if (!present_reg)
                        begin
                            status_next = ST_MISSING;
                            pos_next    = '0;
                        end
                    end
                endcase
            end

            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + PTR_W'(1);
                mem_wdata = rd_data_reg;
                if (ptr_ext == rank_reg)
                begin
                    state_next = S_INSK;
                end
                else
                begin
                    ptr_next  = ptr_reg - PTR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - PTR_W'(1);
                end
            end

            S_INSK:
            begin
                mem_we     = 1'b1;
                mem_waddr  = PTR_W'(rank_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_REM:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - PTR_W'(1);
                mem_wdata = rd_data_reg;
                if (ptr_ext + CNT_W'(1) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    ptr_next  = ptr_reg + PTR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + PTR_W'(1);
                end
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        ptr_reg     <= ptr_next;
        rank_reg    <= rank_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
    end

    skt_result_reg #(
        .POS_BITS (PTR_W),
        .OCC_BITS (CNT_W)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .status    (status_reg),
        .position  (pos_reg),
        .occupancy (count_reg),
        .free      (rsp_free),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("occupancy changed by more than one");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("read and write to the same entry in one cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (state_reg == S_RESP && rsp_free))
        else $error("response loaded while output register busy");
`endif

endmodule

/* design/skt_result_reg.sv */
// ----------------------------------------------------------------------------
// skt_result_reg
// Output register: holds one response word until the sink takes it.
// ----------------------------------------------------------------------------
module skt_result_reg #(
    parameter int POS_BITS = 6,
    parameter int OCC_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  skt_pkg::status_t    status,
    input  logic [POS_BITS-1:0] position,
    input  logic [OCC_BITS-1:0] occupancy,
    output logic                free,
    skt_rsp_if.source           rsp
);
    import skt_pkg::*;

    logic                valid_reg;
    status_t             status_reg;
    logic [POS_BITS-1:0] position_reg;
    logic [OCC_BITS-1:0] occupancy_reg;

    assign free          = !valid_reg || rsp.ready;
    assign rsp.valid     = valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.position  = position_reg;
    assign rsp.occupancy = occupancy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg    <= status;
            position_reg  <= position;
            occupancy_reg <= occupancy;
        end
    end

endmodule

/* verif/sorted_key_table_tb.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A scoreboard keeps its own
// sorted copy of the keys and predicts status, rank and occupancy for every
// accepted request word. Directed words cover the empty table, the extreme
// keys, duplicates, middle, first, last and sole-entry removal, and the
// spare operation code. Random phases then fill the table to capacity,
// churn it and drain it, with bursty idling on both channels, one long
// response hold-off and one full drain.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

    import skt_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 16;
    localparam int POS_BITS     = 6;
    localparam int OCC_BITS     = 7;
    localparam int RANDOM_WORDS = 1750;
    localparam int QUIET_WORDS  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 900000;

    // op code 3 is not named in the package; the block treats it as a lookup
    localparam op_t OP_SPARE = 2'd3;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        status_t             status;
        logic [POS_BITS-1:0] position;
        logic [OCC_BITS-1:0] occupancy;
    } table_result_t;

    class key_table_scoreboard;
        key_t          held[CAPACITY];
        int            count;
        int            errors;
        table_result_t due_responses[$];

        function void note_request(op_t op, key_t k);
            table_result_t r;
            int            rank;
            bit            hit;
            rank = 0;
            while (rank < count && held[rank] < k)
                rank++;
            hit = (rank < count) && (held[rank] == k);
            r.status   = ST_OK;
            r.position = '0;
            case (op)
                OP_INSERT:
                begin
                    if (hit)
                        r.status = ST_DUP;
                    else if (count >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = count; i > rank; i--)
                            held[i] = held[i-1];
                        held[rank] = k;
                        count++;
                        r.position = POS_BITS'(rank);
                    end
                end
                OP_REMOVE:
                begin
                    if (!hit)
                        r.status = ST_MISSING;
                    else
                    begin
                        for (int i = rank; i + 1 < count; i++)
                            held[i] = held[i+1];
                        count--;
                        r.position = POS_BITS'(rank);
                    end
                end
                default:
                begin
                    if (!hit)
                        r.status = ST_MISSING;
                    else
                        r.position = POS_BITS'(rank);
                end
            endcase
            r.occupancy = OCC_BITS'(count);
            due_responses.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_response(status_t status, logic [POS_BITS-1:0] position,
                                     logic [OCC_BITS-1:0] occupancy);
            table_result_t want;
            if (due_responses.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                         $time, status, position, occupancy);
                return;
            end
            want = due_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("position", 32'(want.position), 32'(position));
            compare_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_rsp;
    int   cycle_count;

    key_table_scoreboard sb;

    skt_req_if #(.KEY_BITS(KEY_BITS)) req ();
    skt_rsp_if #(.POS_BITS(POS_BITS), .OCC_BITS(OCC_BITS)) rsp ();

    sorted_key_table #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.status, rsp.position, rsp.occupancy);
    end

    // response side: random stalls, one long hold-off on request
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(op_t op, key_t k);
        req.valid     <= 1'b1;
        req.operation <= op;
        req.key       <= k;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(op, k);
    endtask

    task automatic pause_sender(int cycles);
        req.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_all_responses();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.due_responses.size() != 0)
            @(posedge clk);
    endtask

    function automatic op_t pick_op(int phase);
        int r;
        int ins_pct;
        int rem_pct;
        case (phase)
            0:
            begin
                ins_pct = 80;
                rem_pct = 5;
            end
            2:
            begin
                ins_pct = 10;
                rem_pct = 75;
            end
            default:
            begin
                ins_pct = 35;
                rem_pct = 30;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + rem_pct)
            return OP_REMOVE;
        if (r < 97)
            return OP_LOOKUP;
        return OP_SPARE;
    endfunction

    function automatic key_t pick_key(op_t op);
        int r;
        int hit_pct;
        hit_pct = (op == OP_INSERT) ? 15 : 60;
        r = $urandom_range(0, 99);
        if (sb.count > 0 && r < hit_pct)
            return sb.held[$urandom_range(0, sb.count - 1)];
        r = $urandom_range(0, 99);
        if (r < 20)
            return key_t'($urandom_range(0, 63));
        if (r < 25)
            return r[0] ? {KEY_BITS{1'b1}} : '0;
        return key_t'($urandom);
    endfunction

    initial
    begin
        op_t op;
        sb            = new;
        rst_n         = 1'b0;
        quiet         = 1'b0;
        hold_rsp      = 1'b0;
        cycle_count   = 0;
        req.valid     = 1'b0;
        req.operation = OP_LOOKUP;
        req.key       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, sole entry, extremes, duplicate, spare code
        send_word(OP_LOOKUP, 16'h0000);
        send_word(OP_REMOVE, 16'hFFFF);
        send_word(OP_INSERT, 16'h8000);
        send_word(OP_REMOVE, 16'h8000);
        send_word(OP_INSERT, 16'hFFFF);
        send_word(OP_INSERT, 16'h0000);
        send_word(OP_INSERT, 16'h8000);
        send_word(OP_INSERT, 16'h8000);
        send_word(OP_LOOKUP, 16'hFFFF);
        send_word(OP_SPARE,  16'h0000);
        send_word(OP_SPARE,  16'h1234);
        // middle removal, then the entries above must still be found
        send_word(OP_REMOVE, 16'h8000);
        send_word(OP_LOOKUP, 16'hFFFF);
        send_word(OP_INSERT, 16'h5555);
        send_word(OP_INSERT, 16'hAAAA);
        send_word(OP_REMOVE, 16'h0000);
        send_word(OP_REMOVE, 16'hFFFF);
        send_word(OP_LOOKUP, 16'h5555);
        send_word(OP_LOOKUP, 16'hAAAA);
        send_word(OP_REMOVE, 16'h7FFF);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            if (n == 300)
                hold_rsp = 1'b1;
            if (n == 900)
                wait_all_responses();
            if (!quiet && (n / 200) % 3 != 2 && $urandom_range(0, 9) == 0)
                pause_sender($urandom_range(1, 18));
            op = pick_op((n / 120) % 4);
            send_word(op, pick_key(op));
        end

        wait_all_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due_responses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
